// ===== rtl/xbr_pkg.sv =====
// Package for the XMODEM boot receiver: result kinds, modes, field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package xbr_pkg;

    localparam int PAYLOAD_BYTES    = 128;
    localparam int PACKETS_PER_PAGE = 16;
    localparam int WAIT_TICKS       = 30;
    localparam int TICKS_PER_PROMPT = 10;
    localparam int MENU_TICKS       = 50;
    localparam int POLL_TICKS       = 2;
    localparam int WORDS_PER_FRAME  = PAYLOAD_BYTES / 8;
    localparam int FRAME_BYTES      = PAYLOAD_BYTES + 5;

    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] EOT_BYTE = 8'h04;
    localparam logic [7:0] CHAR_LA  = 8'h61;
    localparam logic [7:0] CHAR_UA  = 8'h41;
    localparam logic [7:0] CHAR_UB  = 8'h42;
    localparam logic [7:0] CHAR_UC  = 8'h43;

    typedef enum logic [3:0] {
        KIND_ACK     = 4'd0,
        KIND_NAK     = 4'd1,
        KIND_PROMPT  = 4'd2,
        KIND_JUMP    = 4'd3,
        KIND_MENU    = 4'd4,
        KIND_CMD_ERR = 4'd5,
        KIND_RESET   = 4'd6,
        KIND_WARN    = 4'd7,
        KIND_SEND_C  = 4'd8,
        KIND_STORE   = 4'd9,
        KIND_PROGRAM = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_MENU   = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_HALT   = 2'd3
    } mode_t;

    // controller -> datapath
    typedef struct packed {
        logic       take_byte;   // absorb a received byte
        logic       take_tick;   // evaluate a tick
        logic       word_step;   // advance store-word readout
        logic       emit;        // load result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       store_run;   // readout pending
        logic       word_last;   // current word is the last
        logic       have_result; // decision yields results
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/xbr_stream_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface xbr_stream_if #(parameter int WIDTH = 8);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/xbr_datapath.sv =====
// Datapath: frame state, CRC, payload memory, result formation.
// Depends on xbr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xbr_datapath #(
    parameter int PACKETS_PER_PAGE = xbr_pkg::PACKETS_PER_PAGE,
    parameter int WAIT_TICKS       = xbr_pkg::WAIT_TICKS,
    parameter int TICKS_PER_PROMPT = xbr_pkg::TICKS_PER_PROMPT,
    parameter int MENU_TICKS       = xbr_pkg::MENU_TICKS,
    parameter int POLL_TICKS       = xbr_pkg::POLL_TICKS
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire  [7:0]              in_byte,
    input  wire                     in_end,
    input  xbr_pkg::dp_cmd_t        cmd,
    output xbr_pkg::dp_status_t     status,
    output logic [3:0]              r_kind,
    output logic [63:0]             r_word,
    output logic [22:0]             r_addr,
    output logic [15:0]             r_count,
    output logic [3:0]              r_partial,
    output logic                    r_last
);
    localparam int WCNT = xbr_pkg::WORDS_PER_FRAME;

    // decision results: up to two simple results plus optional readout
    xbr_pkg::mode_t mode_reg, mode_next;
    logic [4:0]  wait_reg, wait_next;
    logic [5:0]  menu_reg, menu_next;
    logic [1:0]  poll_reg, poll_next;
    logic [2:0]  flags_reg, flags_next;
    logic [15:0] pkt_reg, pkt_next;
    logic [12:0] page_reg, page_next;
    logic [3:0]  part_reg, part_next;
    logic [5:0]  pos_reg, pos_next;      // packet count within the current page
    logic [7:0]  len_reg, first_reg;
    logic [15:0] crc_reg, crcr_reg;

    // pending results queue (two slots) and readout
    logic [1:0]  npend_reg, npend_next;
    logic [3:0]  k0_reg, k0_next, k1_reg, k1_next;
    logic [15:0] c0_reg, c0_next;
    logic [3:0]  p0_reg, p0_next;
    logic        store_reg, store_next;
    logic [3:0]  widx_reg;
    logic [15:0] base_reg;

    // payload as sixteen words, one byte lane written per byte
    logic [63:0] mem [WCNT];
    logic [63:0] rd_reg;
    logic [6:0]  wr_addr;

    // CRC of one byte, eight bit steps
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
        return x;
    endfunction

    // prompt decode per wait count: {prompt due, seconds left}
    function automatic logic [5:0] prompt_info(input logic [4:0] w);
        logic [5:0] r;
        r = 6'd0;
        for (int i = 0; i < 32; i++)
            if (w == 5'(i))
                r = {(i % TICKS_PER_PROMPT) == 0,
                     (i <= WAIT_TICKS) ? 5'((WAIT_TICKS - i) / TICKS_PER_PROMPT) : 5'd0};
        return r;
    endfunction

    logic [7:0] len1;
    logic       soft_reset;
    logic [15:0] pkt_inc;
    logic [4:0]  w_inc;
    logic [5:0]  m_inc;
    logic [1:0]  p_inc;
    logic [5:0]  pos_inc;
    logic [5:0]  pinfo;

    assign len1    = (len_reg == 8'hFF) ? 8'hFF : len_reg + 8'd1;
    assign pkt_inc = pkt_reg + 16'd1;
    assign w_inc   = wait_reg + 5'd1;
    assign m_inc   = menu_reg + 6'd1;
    assign p_inc   = poll_reg + 2'd1;
    assign pinfo   = prompt_info(w_inc);
    // page position follows the packet count, including its 16-bit wrap
    assign pos_inc = (pkt_inc == 16'd0
                      || ({1'b0, pos_reg} + 7'd1) == 7'(PACKETS_PER_PAGE))
                     ? 6'd0 : pos_reg + 6'd1;
    assign wr_addr = 7'(len_reg - 8'd3);

    // decision logic
    always_comb
    begin
        mode_next = mode_reg; wait_next = wait_reg; menu_next = menu_reg;
        poll_next = poll_reg; flags_next = flags_reg; pkt_next = pkt_reg;
        page_next = page_reg; part_next = part_reg; pos_next = pos_reg;
        npend_next = 2'd0; k0_next = k0_reg; k1_next = k1_reg;
        c0_next = 16'd0; p0_next = 4'd0; store_next = 1'b0;
        soft_reset = 1'b0;
        if (cmd.take_tick) begin
            unique case (mode_reg)
                xbr_pkg::MODE_WAIT:
                begin
                    wait_next = w_inc;
                    if (pinfo[5]) begin
                        npend_next = 2'd1; k0_next = xbr_pkg::KIND_PROMPT;
                        c0_next = {11'd0, pinfo[4:0]};
                    end
                    if (w_inc == 5'(WAIT_TICKS)) begin
                        if (npend_next == 2'd1) begin
                            k1_next = xbr_pkg::KIND_JUMP; npend_next = 2'd2;
                        end else begin
                            k0_next = xbr_pkg::KIND_JUMP; npend_next = 2'd1;
                        end
                        mode_next = xbr_pkg::MODE_HALT;
                    end
                end
                xbr_pkg::MODE_MENU:
                begin
                    menu_next = m_inc;
                    if (m_inc == 6'(MENU_TICKS)) begin
                        menu_next = 6'd0; npend_next = 2'd1; k0_next = xbr_pkg::KIND_MENU;
                    end
                end
                xbr_pkg::MODE_UPDATE:
                begin
                    if (flags_reg[0]) begin
                        npend_next = 2'd1; k0_next = xbr_pkg::KIND_WARN;
                        flags_next = {flags_reg[2], 2'b10};
                    end else if (flags_reg[1]) begin
                        poll_next = p_inc;
                        if (p_inc == 2'(POLL_TICKS)) begin
                            poll_next = 2'd0; npend_next = 2'd1;
                            k0_next = xbr_pkg::KIND_SEND_C;
                        end
                    end else if (flags_reg[2]) begin
                        npend_next = 2'd2; k0_next = xbr_pkg::KIND_PROGRAM;
                        k1_next = xbr_pkg::KIND_RESET;
                        c0_next = {3'd0, page_reg}; p0_next = part_reg;
                        soft_reset = 1'b1;
                    end
                end
                default: ;
            endcase
        end else if (cmd.take_byte && in_end) begin
            unique case (mode_reg)
                xbr_pkg::MODE_WAIT:
                begin
                    if (len1 == 8'd1 && (len_reg == 8'd0 ? in_byte : first_reg)
                        == xbr_pkg::CHAR_LA) begin
                        mode_next = xbr_pkg::MODE_MENU;
                        menu_next = 6'(MENU_TICKS - 1);
                    end
                end
                xbr_pkg::MODE_MENU:
                begin
                    npend_next = 2'd1;
                    if (len1 == 8'd1 && in_byte == xbr_pkg::CHAR_UA) begin
                        npend_next = 2'd0; mode_next = xbr_pkg::MODE_UPDATE;
                        flags_next = flags_reg | 3'b001;
                    end else if (len1 == 8'd1 && in_byte == xbr_pkg::CHAR_UB) begin
                        k0_next = xbr_pkg::KIND_JUMP; mode_next = xbr_pkg::MODE_HALT;
                    end else if (len1 == 8'd1 && in_byte == xbr_pkg::CHAR_UC) begin
                        k0_next = xbr_pkg::KIND_RESET; soft_reset = 1'b1;
                    end else begin
                        k0_next = xbr_pkg::KIND_CMD_ERR;
                    end
                end
                xbr_pkg::MODE_UPDATE:
                begin
                    npend_next = 2'd1;
                    if (first_reg == xbr_pkg::SOH_BYTE
                        && len1 == 8'(xbr_pkg::FRAME_BYTES)) begin
                        flags_next = flags_reg & 3'b101;
                        if (crc_reg == {crcr_reg[15:8], in_byte}) begin
                            pkt_next = pkt_inc; pos_next = pos_inc; store_next = 1'b1;
                            k0_next = xbr_pkg::KIND_ACK;
                            if (pos_inc == 6'd0)
                                page_next = page_reg + 13'd1;
                        end else begin
                            k0_next = xbr_pkg::KIND_NAK;
                        end
                    end else if (len1 == 8'd1 && in_byte == xbr_pkg::EOT_BYTE) begin
                        k0_next = xbr_pkg::KIND_ACK;
                        if (pos_reg != 6'd0) begin
                            part_next = pos_reg[3:0];
                            page_next = page_reg + 13'd1;
                        end
                        flags_next = flags_reg | 3'b100;
                    end else begin
                        k0_next = xbr_pkg::KIND_NAK;
                    end
                end
                default: npend_next = 2'd0;
            endcase
        end
        // reset request returns the control state to power-on values
        if (soft_reset) begin
            mode_next = xbr_pkg::MODE_WAIT; wait_next = 5'd0; menu_next = 6'd0;
            poll_next = 2'd0; flags_next = 3'd0; pkt_next = 16'd0;
            page_next = 13'd0; part_next = 4'd0; pos_next = 6'd0;
        end
    end

    assign status.have_result = (npend_reg != 2'd0) || store_reg;
    assign status.store_run   = store_reg;
    assign status.word_last   = (widx_reg == 4'(WCNT - 1));

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= xbr_pkg::MODE_WAIT; wait_reg <= '0; menu_reg <= '0;
            poll_reg <= '0; flags_reg <= '0; pkt_reg <= '0; page_reg <= '0;
            part_reg <= '0; pos_reg <= '0; len_reg <= '0; first_reg <= '0; crc_reg <= '0;
            crcr_reg <= '0; npend_reg <= '0; store_reg <= 1'b0; widx_reg <= '0;
            k0_reg <= '0; k1_reg <= '0; c0_reg <= '0; p0_reg <= '0; base_reg <= '0;
        end else begin
            if (cmd.take_byte || cmd.take_tick) begin
                mode_reg <= mode_next; wait_reg <= wait_next; menu_reg <= menu_next;
                poll_reg <= poll_next; flags_reg <= flags_next; pkt_reg <= pkt_next;
                page_reg <= page_next; part_reg <= part_next; pos_reg <= pos_next;
                npend_reg <= npend_next; store_reg <= store_next; widx_reg <= '0;
                k0_reg <= k0_next; k1_reg <= k1_next; c0_reg <= c0_next;
                p0_reg <= p0_next; base_reg <= pkt_reg;
                if (soft_reset) begin
                    first_reg <= '0; crcr_reg <= '0;
                end
            end
            // byte framing
            if (cmd.take_byte) begin
                if (len_reg == 8'd0 && !soft_reset) first_reg <= in_byte;
                if (len_reg == 8'(xbr_pkg::FRAME_BYTES - 2)) crcr_reg[15:8] <= in_byte;
                if (len_reg == 8'(xbr_pkg::FRAME_BYTES - 1)) crcr_reg[7:0] <= in_byte;
                if (in_end) begin
                    len_reg <= '0; crc_reg <= '0;
                end else begin
                    len_reg <= len1;
                    if (len_reg >= 8'd3 && len_reg < 8'(xbr_pkg::FRAME_BYTES - 2))
                        crc_reg <= crc_byte(crc_reg, in_byte);
                end
            end else if (soft_reset) begin
                len_reg <= '0; crc_reg <= '0;
            end
            // result queue advance
            if (cmd.emit) begin
                if (store_reg) begin
                    if (status.word_last) store_reg <= 1'b0;
                    else widx_reg <= widx_reg + 4'd1;
                end else begin
                    npend_reg <= npend_reg - 2'd1;
                    k0_reg <= k1_reg; c0_reg <= '0; p0_reg <= '0;
                end
            end
        end
    end

    // payload memory, one byte lane written, one word read
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && len_reg >= 8'd3 && len_reg < 8'(xbr_pkg::FRAME_BYTES - 2))
            mem[wr_addr[6:3]][{wr_addr[2:0], 3'd0} +: 8] <= in_byte;
        if (cmd.word_step || cmd.take_byte || cmd.take_tick)
            rd_reg <= mem[cmd.word_step ? widx_reg + 4'd1 : 4'd0];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            if (store_reg) begin
                r_kind <= xbr_pkg::KIND_STORE; r_word <= rd_reg;
                r_addr <= 23'({base_reg, 7'd0} + {widx_reg, 3'd0});
                r_count <= '0; r_partial <= '0; r_last <= 1'b0;
            end else begin
                r_kind <= k0_reg; r_word <= '0; r_addr <= '0;
                r_count <= c0_reg; r_partial <= p0_reg;
                r_last <= (npend_reg == 2'd1);
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/xbr_ctrl.sv =====
// Controller: sequences accept, evaluation and result delivery.
// Depends on xbr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xbr_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire                  in_op,
    input  wire                  out_ready,
    output logic                 out_valid,
    input  xbr_pkg::dp_status_t  status,
    output xbr_pkg::dp_cmd_t     cmd
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EVAL = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   acc, take, fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign acc       = in_valid && in_ready;
    assign out_valid = ov_reg;
    // result register free when empty or being taken
    assign take      = !ov_reg || out_ready;
    assign fire      = (state_reg == ST_EMIT) && take;

    always_comb
    begin
        cmd.take_byte = acc && !in_op;
        cmd.take_tick = acc && in_op;
        cmd.emit      = fire;
        cmd.word_step = fire && status.store_run;
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE: if (acc) state_next = ST_EVAL;
            ST_EVAL: state_next = status.have_result ? ST_EMIT : ST_IDLE;
            ST_EMIT:
            begin
                if (fire) begin
                    ov_next = 1'b1;
                    if (!(status.store_run && !status.word_last)
                        && !(!status.store_run && status.have_result && 1'b0))
                        state_next = ST_EVAL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/xmodem_boot_receiver_core.sv =====
// Top level of the XMODEM boot receiver: controller plus datapath.
// Depends on xbr_pkg, xbr_stream_if, xbr_ctrl, xbr_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Takes one byte or tick word at a time. A byte or tick with no result
// passes through the accept and one evaluation state. Each ack, nak or
// other simple result adds an emit and an evaluation state; store words
// follow one per cycle while the output is free, from the single-word
// read port of the payload memory, so a good frame's last byte yields
// sixteen store words and an ACK before the next word is accepted.
module xmodem_boot_receiver_core #(
    parameter int PACKETS_PER_PAGE = xbr_pkg::PACKETS_PER_PAGE,
    parameter int WAIT_TICKS       = xbr_pkg::WAIT_TICKS,
    parameter int TICKS_PER_PROMPT = xbr_pkg::TICKS_PER_PROMPT,
    parameter int MENU_TICKS       = xbr_pkg::MENU_TICKS,
    parameter int POLL_TICKS       = xbr_pkg::POLL_TICKS
) (
    input  wire     clk,
    input  wire     rst_n,
    xbr_stream_if.sink   in_ch,
    xbr_stream_if.source out_ch
);
    // in payload: {frame_end, data_byte, operation}
    // out payload: {last, partial_packets, count_value, byte_address, data_word, kind}
    xbr_pkg::dp_cmd_t    cmd;
    xbr_pkg::dp_status_t status;
    logic [3:0]  r_kind;
    logic [63:0] r_word;
    logic [22:0] r_addr;
    logic [15:0] r_count;
    logic [3:0]  r_partial;
    logic        r_last;

    xbr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.data[0]),
        .out_ready(out_ch.ready), .out_valid(out_ch.valid),
        .status(status), .cmd(cmd)
    );

    xbr_datapath #(
        .PACKETS_PER_PAGE(PACKETS_PER_PAGE), .WAIT_TICKS(WAIT_TICKS),
        .TICKS_PER_PROMPT(TICKS_PER_PROMPT), .MENU_TICKS(MENU_TICKS),
        .POLL_TICKS(POLL_TICKS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_byte(in_ch.data[8:1]), .in_end(in_ch.data[9]),
        .cmd(cmd), .status(status),
        .r_kind(r_kind), .r_word(r_word), .r_addr(r_addr), .r_count(r_count),
        .r_partial(r_partial), .r_last(r_last)
    );

    assign out_ch.data = {r_last, r_partial, r_count, r_addr, r_word, r_kind};

    // no input taken while store words are read out
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.store_run |-> !in_ch.ready)
        else $error("input accepted during readout");
    // a store word is never flagged last
    a_store_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data[3:0] == 4'(xbr_pkg::KIND_STORE)) |-> !out_ch.data[111])
        else $error("store word marked last");
endmodule
`default_nettype wire

// ===== sim/xbr_scoreboard.sv =====
// Boot receiver scoreboard: bit-exact predictor of the result words plus the check.
// Depends on xbr_pkg.
`timescale 1ns / 1ps

typedef struct packed {
    logic       frame_end;
    logic [7:0] rx_byte;
    logic       op;
} xbr_item_t;

typedef struct packed {
    logic           last;
    logic [3:0]     partial_packets;
    logic [15:0]    count_value;
    logic [22:0]    byte_address;
    logic [63:0]    data_word;
    xbr_pkg::kind_t kind;
} xbr_result_t;

class boot_scoreboard;
    xbr_pkg::mode_t mode;
    int unsigned    wait_cnt;
    int unsigned    menu_cnt;
    int unsigned    poll_cnt;
    bit             warn_due;
    bit             c_due;
    bit             prog_due;
    bit [15:0]      packets;
    bit [12:0]      pages;
    bit [3:0]       partial;
    int unsigned    frame_len;
    bit [7:0]       first;
    bit [15:0]      crc_run;
    bit [15:0]      crc_rx;
    bit [7:0]       payload [xbr_pkg::PAYLOAD_BYTES];
    xbr_result_t    pending [$];
    int             errors;

    function new();
        clear();
        errors = 0;
    endfunction

    // power-on state; payload store survives a reset request
    function void clear();
        mode      = xbr_pkg::MODE_WAIT;
        wait_cnt  = 0;
        menu_cnt  = 0;
        poll_cnt  = 0;
        warn_due  = 0;
        c_due     = 0;
        prog_due  = 0;
        packets   = 0;
        pages     = 0;
        partial   = 0;
        frame_len = 0;
        first     = 0;
        crc_run   = 0;
        crc_rx    = 0;
    endfunction

    function void push(xbr_pkg::kind_t k, bit [63:0] w = 0, bit [22:0] a = 0,
                       bit [15:0] c = 0, bit [3:0] p = 0);
        xbr_result_t r;
        r.kind = k;
        r.data_word = w;
        r.byte_address = a;
        r.count_value = c;
        r.partial_packets = p;
        r.last = 1'b0;
        pending.push_back(r);
    endfunction

    // CRC-16/XMODEM, one byte, MSB first
    function bit [15:0] crc_update(bit [15:0] c, bit [7:0] b);
        c = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function void on_tick();
        int unsigned left;
        case (mode)
            xbr_pkg::MODE_WAIT:
            begin
                wait_cnt = (wait_cnt + 1) & 31;
                if (wait_cnt % xbr_pkg::TICKS_PER_PROMPT == 0)
                begin
                    left = (wait_cnt <= xbr_pkg::WAIT_TICKS) ?
                        (xbr_pkg::WAIT_TICKS - wait_cnt) / xbr_pkg::TICKS_PER_PROMPT : 0;
                    push(xbr_pkg::KIND_PROMPT, 0, 0, left[15:0]);
                end
                if (wait_cnt == xbr_pkg::WAIT_TICKS)
                begin
                    push(xbr_pkg::KIND_JUMP);
                    mode = xbr_pkg::MODE_HALT;
                end
            end
            xbr_pkg::MODE_MENU:
            begin
                menu_cnt = (menu_cnt + 1) & 63;
                if (menu_cnt == xbr_pkg::MENU_TICKS)
                begin
                    menu_cnt = 0;
                    push(xbr_pkg::KIND_MENU);
                end
            end
            xbr_pkg::MODE_UPDATE:
            begin
                if (warn_due)
                begin
                    push(xbr_pkg::KIND_WARN);
                    warn_due = 0;
                    c_due = 1;
                end
                else if (c_due)
                begin
                    poll_cnt = (poll_cnt + 1) & 3;
                    if (poll_cnt == xbr_pkg::POLL_TICKS)
                    begin
                        poll_cnt = 0;
                        push(xbr_pkg::KIND_SEND_C);
                    end
                end
                else if (prog_due)
                begin
                    push(xbr_pkg::KIND_PROGRAM, 0, 0, {3'b0, pages}, partial);
                    push(xbr_pkg::KIND_RESET);
                    clear();
                end
            end
            default: ;
        endcase
    endfunction

    function void on_frame(int unsigned len);
        bit [63:0] w;
        bit [22:0] base;
        case (mode)
            xbr_pkg::MODE_WAIT:
                if (len == 1 && first == xbr_pkg::CHAR_LA)
                begin
                    mode = xbr_pkg::MODE_MENU;
                    menu_cnt = (xbr_pkg::MENU_TICKS - 1) & 63;
                end
            xbr_pkg::MODE_MENU:
                if (len == 1 && first == xbr_pkg::CHAR_UA)
                begin
                    mode = xbr_pkg::MODE_UPDATE;
                    warn_due = 1;
                end
                else if (len == 1 && first == xbr_pkg::CHAR_UB)
                begin
                    push(xbr_pkg::KIND_JUMP);
                    mode = xbr_pkg::MODE_HALT;
                end
                else if (len == 1 && first == xbr_pkg::CHAR_UC)
                begin
                    push(xbr_pkg::KIND_RESET);
                    clear();
                end
                else
                    push(xbr_pkg::KIND_CMD_ERR);
            xbr_pkg::MODE_UPDATE:
                if (first == xbr_pkg::SOH_BYTE && len == xbr_pkg::FRAME_BYTES)
                begin
                    c_due = 0;
                    if (crc_run == crc_rx)
                    begin
                        packets = packets + 1;
                        base = 23'(packets - 16'd1) << 7;
                        for (int k = 0; k < xbr_pkg::WORDS_PER_FRAME; k++)
                        begin
                            for (int j = 0; j < 8; j++)
                                w[8*j +: 8] = payload[8*k + j];
                            push(xbr_pkg::KIND_STORE, w, base + 23'(8 * k));
                        end
                        if (packets % xbr_pkg::PACKETS_PER_PAGE == 0)
                            pages = pages + 1;
                        push(xbr_pkg::KIND_ACK);
                    end
                    else
                        push(xbr_pkg::KIND_NAK);
                end
                else if (len == 1 && first == xbr_pkg::EOT_BYTE)
                begin
                    push(xbr_pkg::KIND_ACK);
                    if (packets % xbr_pkg::PACKETS_PER_PAGE != 0)
                    begin
                        partial = 4'(packets % xbr_pkg::PACKETS_PER_PAGE);
                        pages = pages + 1;
                    end
                    prog_due = 1;
                end
                else
                    push(xbr_pkg::KIND_NAK);
            default: ;
        endcase
    endfunction

    // an accepted input word: work out the result words it causes
    function void note_input(xbr_item_t it);
        int          n0;
        int unsigned pos;
        int unsigned len;
        xbr_result_t tail;
        n0 = pending.size();
        if (it.op)
            on_tick();
        else
        begin
            pos = frame_len;
            len = (pos < 255) ? pos + 1 : 255;
            if (pos == 0)
                first = it.rx_byte;
            if (pos >= 3 && pos < 3 + xbr_pkg::PAYLOAD_BYTES)
            begin
                payload[pos - 3] = it.rx_byte;
                crc_run = crc_update(crc_run, it.rx_byte);
            end
            else if (pos == 3 + xbr_pkg::PAYLOAD_BYTES)
                crc_rx[15:8] = it.rx_byte;
            else if (pos == 4 + xbr_pkg::PAYLOAD_BYTES)
                crc_rx[7:0] = it.rx_byte;
            if (it.frame_end)
            begin
                frame_len = len;
                if (mode != xbr_pkg::MODE_HALT)
                    on_frame(len);
                frame_len = 0;
                crc_run = 0;
            end
            else
                frame_len = len;
        end
        if (pending.size() > n0)
        begin
            tail = pending.pop_back();
            tail.last = 1'b1;
            pending.push_back(tail);
        end
    endfunction

    function void check_result(xbr_result_t got);
        xbr_result_t exp;
        if (pending.size() == 0)
        begin
            $error("unexpected result word kind=%0d", got.kind);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.kind !== exp.kind)
        begin
            $error("kind: expected %0d, got %0d", exp.kind, got.kind);
            errors++;
        end
        if (got.data_word !== exp.data_word)
        begin
            $error("data_word: expected %h, got %h", exp.data_word, got.data_word);
            errors++;
        end
        if (got.byte_address !== exp.byte_address)
        begin
            $error("byte_address: expected %h, got %h", exp.byte_address, got.byte_address);
            errors++;
        end
        if (got.count_value !== exp.count_value)
        begin
            $error("count_value: expected %0d, got %0d", exp.count_value, got.count_value);
            errors++;
        end
        if (got.partial_packets !== exp.partial_packets)
        begin
            $error("partial_packets: expected %0d, got %0d",
                   exp.partial_packets, got.partial_packets);
            errors++;
        end
        if (got.last !== exp.last)
        begin
            $error("last: expected %0d, got %0d", exp.last, got.last);
            errors++;
        end
    endfunction
endclass

// ===== sim/xmodem_boot_receiver_core_tb.sv =====
// Testbench for xmodem_boot_receiver_core: directed boot flow, then random sessions.
// Depends on xbr_pkg, xbr_stream_if, sim/xbr_scoreboard.sv and the RTL.
`timescale 1ns / 1ps

module xmodem_boot_receiver_core_tb;

    localparam int RANDOM_ITEMS = 300;
    localparam int STALL_LIMIT  = 5000;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   snk_stall_pct;
    int   rand_items;
    bit   rand_part;
    int   quiet_cycles;

    xbr_stream_if #(.WIDTH(10))  in_ch ();
    xbr_stream_if #(.WIDTH(112)) out_ch ();

    boot_scoreboard sb = new();

    xmodem_boot_receiver_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: random stall, check on each accepted word
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(xbr_result_t'(out_ch.data));

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // one input word; idling follows the phase of the random part
    task automatic send_item(bit op, bit [7:0] b, bit fe);
        xbr_item_t it;
        int        ph;
        if (rand_part)
        begin
            ph = rand_items * 4 / RANDOM_ITEMS;
            src_idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 11 : 0;
            snk_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 11 : 0;
            rand_items++;
        end
        it.op = op;
        it.rx_byte = b;
        it.frame_end = fe;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_input(it);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic send_tick();
        send_item(1'b1, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_frame(bit [7:0] bytes [$]);
        foreach (bytes[i])
            send_item(1'b0, bytes[i], i == bytes.size() - 1);
    endtask

    // XMODEM data frame with random payload; bad_crc flips one bit of the check bytes
    task automatic send_packet(bit bad_crc, bit [7:0] header = xbr_pkg::SOH_BYTE);
        bit [7:0]  f [$];
        bit [7:0]  blk;
        bit [7:0]  d;
        bit [15:0] crc;
        blk = 8'($urandom);
        crc = 0;
        f = {header, blk, ~blk};
        for (int i = 0; i < xbr_pkg::PAYLOAD_BYTES; i++)
        begin
            d = 8'($urandom);
            f.push_back(d);
            crc = sb.crc_update(crc, d);
        end
        if (bad_crc)
            crc ^= 16'(1 << $urandom_range(15));
        f.push_back(crc[15:8]);
        f.push_back(crc[7:0]);
        send_frame(f);
    endtask

    task automatic send_noise(int unsigned lo, int unsigned hi);
        bit [7:0] f [$];
        repeat ($urandom_range(hi, lo))
            f.push_back(8'($urandom));
        send_frame(f);
    endtask

    task automatic random_step();
        int unsigned r;
        bit [7:0]    c;
        r = $urandom_range(15);
        case (sb.mode)
            xbr_pkg::MODE_WAIT:
                if (r < 10 && sb.wait_cnt < xbr_pkg::WAIT_TICKS - 2)
                    send_tick();
                else if (r < 12)
                    send_noise(1, 3);
                else
                    send_frame('{xbr_pkg::CHAR_LA});
            xbr_pkg::MODE_MENU:
                if (r < 3)
                    send_tick();
                else if (r < 5)
                begin
                    c = 8'($urandom);
                    if (c == xbr_pkg::CHAR_UB)
                        c = xbr_pkg::CHAR_UA;
                    if ($urandom_range(1))
                        send_frame('{c});
                    else
                        send_frame('{c, 8'($urandom)});
                end
                else if (r == 5)
                    send_frame('{xbr_pkg::CHAR_UC});
                else
                    send_frame('{xbr_pkg::CHAR_UA});
            default:
                if (r < 6)
                    send_tick();
                else if (r < 9)
                    send_packet(1'b0);
                else if (r == 9)
                    send_packet(1'b1);
                else if (r == 10)
                    send_noise(1, 5);
                else if (r == 11)
                    send_noise(134, ($urandom_range(3) == 0) ? 262 : 140);
                else if (r == 12)
                    send_packet(1'b0, 8'($urandom));
                else
                    send_frame('{xbr_pkg::EOT_BYTE});
        endcase
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        rand_items    = 0;
        rand_part     = 0;
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: prompt, menu entry, menu timeout, bad command, update flow
        repeat (10) send_tick();
        send_frame('{xbr_pkg::CHAR_LA});
        send_tick();
        send_frame('{8'hFF, 8'h00});
        send_frame('{xbr_pkg::CHAR_UA});
        send_frame('{xbr_pkg::EOT_BYTE});
        repeat (3) send_tick();
        send_packet(1'b0);
        send_frame('{xbr_pkg::SOH_BYTE, 8'h78});
        send_frame('{xbr_pkg::EOT_BYTE});
        send_tick();

        // random sessions
        rand_part = 1;
        while (rand_items < RANDOM_ITEMS)
            random_step();

        // bring the block back to wait mode, then end with a jump
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        rand_part = 0;
        while (sb.mode != xbr_pkg::MODE_WAIT)
        begin
            if (sb.mode == xbr_pkg::MODE_MENU)
                send_frame('{xbr_pkg::CHAR_UC});
            else
            begin
                while (sb.warn_due)
                    send_tick();
                if (sb.c_due)
                    send_packet(1'b0);
                send_frame('{xbr_pkg::EOT_BYTE});
                while (sb.mode == xbr_pkg::MODE_UPDATE)
                    send_tick();
            end
        end
        if ($urandom_range(1))
        begin
            send_frame('{xbr_pkg::CHAR_LA});
            send_frame('{xbr_pkg::CHAR_UB});
        end
        else
            while (sb.mode == xbr_pkg::MODE_WAIT)
                send_tick();
        // halted: all of these are ignored
        send_tick();
        send_frame('{xbr_pkg::CHAR_LA});
        wait_drained();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
